### rtl/core/elr_pkg.sv
package elr_pkg;

  // Sizes
  localparam int MaxVertices = 1024;
  localparam int MaxEdges    = 4096;
  localparam int VtxW        = 10;
  localparam int LimW        = 11;
  localparam int EdgeAw      = 12;
  localparam int CntW        = 13;
  localparam int TypeW       = 32;

  // Operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_BUILD  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  // One result word
  typedef struct packed {
    logic [11:0]      edge_number;
    logic [TypeW-1:0] edge_type_out;
    logic [VtxW-1:0]  neighbor_vertex;
    logic [CntW-1:0]  edge_total;
    logic [CntW-1:0]  degree_count;
    logic [CntW-1:0]  start_position;
    logic [1:0]       status;
  } res_t;

endpackage

### rtl/core/edge_list_to_reverse_csr_unit.sv
// Incoming-edge CSR index builder.
// Input words on in_* carry an operation: append edge, build index, query
// vertex or read in-edge. Every accepted word gives exactly one result word
// on out_*. cfg_wr_en/cfg_wr_data set the vertex limit (saturated at 1024);
// the user writes the limit only while the block is idle (not enforced).
// Append, and any rejected query or read, answers in the cycle after
// acceptance; a query or read that hits memory first waits in S_QRY or
// S_RDE for the read of the vertex table or the in-edge store, then its
// result is registered. One item is in work at a time.
// Build: clears 1024 degree counters, counts edges (read, check, write if
// in range), forms prefix offsets for each vertex and scatters edges (read,
// check, write if in range); in_tready stays low meanwhile.
// Reset empties the edge list, marks the index unbuilt and sets the limit to
// 1024; memory contents are not cleared.
// A result waits in the output register while out_tready is low; a new word
// is taken only once that register is free or being emptied.
module edge_list_to_reverse_csr_unit
  import elr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[1:0], source[11:2], dst_vertex[21:12], type_tag[53:22],
  // position[65:54], zero pad
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], start_position[14:2], degree_count[27:15], edge_total[40:28],
  // neighbor_vertex[50:41], edge_type_out[82:51], edge_number[94:83], zero pad
  output logic [95:0] out_tdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_CNT_RD = 4'd2;
  localparam logic [3:0] S_CNT_CK = 4'd3;
  localparam logic [3:0] S_CNT_WR = 4'd4;
  localparam logic [3:0] S_PRE_RD = 4'd5;
  localparam logic [3:0] S_PRE_WR = 4'd6;
  localparam logic [3:0] S_SC_RD  = 4'd7;
  localparam logic [3:0] S_SC_CK  = 4'd8;
  localparam logic [3:0] S_SC_WR  = 4'd9;
  localparam logic [3:0] S_QRY    = 4'd10;
  localparam logic [3:0] S_RDE    = 4'd11;

  // Input fields
  logic [1:0]       in_op;
  logic [VtxW-1:0]  in_src, in_dst;
  logic [TypeW-1:0] in_type;
  logic [11:0]      in_pos;
  assign in_op   = in_tdata[1:0];
  assign in_src  = in_tdata[11:2];
  assign in_dst  = in_tdata[21:12];
  assign in_type = in_tdata[53:22];
  assign in_pos  = in_tdata[65:54];

  // Control registers
  logic [3:0]      state_r, state_nxt;
  logic [LimW-1:0] vlim_r;
  logic [CntW-1:0] stored_r, stored_nxt;
  logic [CntW-1:0] total_r, total_nxt;
  logic            built_r, built_nxt;
  logic [LimW-1:0] vtx_r, vtx_nxt;
  logic [CntW-1:0] edg_r, edg_nxt;
  logic [CntW-1:0] sum_r, sum_nxt;
  logic            out_valid_r;
  res_t            res_r, res_nxt;
  logic            res_vld;

  logic [LimW-1:0] lim;
  assign lim = (vlim_r > LimW'(MaxVertices)) ? LimW'(MaxVertices) : vlim_r;

  // Memories
  logic            e_we;
  logic [51:0]     e_rd;
  logic            c_we;
  logic [VtxW-1:0] c_wa, c_ra;
  logic [CntW-1:0] c_wd, c_rd;
  logic            v_we;
  logic [VtxW-1:0] v_ra;
  logic [25:0]     v_wd, v_rd;
  logic            i_we;
  logic [11:0]     i_wa, i_ra;
  logic [53:0]     i_wd, i_rd;

  // edge word: src[9:0], dst[19:10], type[51:20]
  elr_ram #(.WIDTH(52), .AW(EdgeAw)) u_edge (
    .clk(clk), .we(e_we), .waddr(stored_r[11:0]),
    .wdata({in_type, in_dst, in_src}), .raddr(edg_r[11:0]), .rdata(e_rd)
  );
  // degree counters, later insert cursors
  elr_ram #(.WIDTH(CntW), .AW(VtxW)) u_cnt (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
  );
  // vertex table: start[12:0], degree[25:13]
  elr_ram #(.WIDTH(26), .AW(VtxW)) u_vtab (
    .clk(clk), .we(v_we), .waddr(vtx_r[VtxW-1:0]), .wdata(v_wd),
    .raddr(v_ra), .rdata(v_rd)
  );
  // in-edge word: nbr[9:0], type[41:10], id[53:42]
  elr_ram #(.WIDTH(54), .AW(EdgeAw)) u_inedge (
    .clk(clk), .we(i_we), .waddr(i_wa), .wdata(i_wd), .raddr(i_ra), .rdata(i_rd)
  );

  logic [VtxW-1:0] e_src, e_dst;
  logic            e_ok;
  assign e_src = e_rd[9:0];
  assign e_dst = e_rd[19:10];
  assign e_ok  = ({1'b0, e_src} < lim) && ({1'b0, e_dst} < lim);

  logic accept;
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  logic last_edge;
  assign last_edge = (edg_r + CntW'(1)) == stored_r;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    stored_nxt = stored_r;
    total_nxt  = total_r;
    built_nxt  = built_r;
    vtx_nxt    = vtx_r;
    edg_nxt    = edg_r;
    sum_nxt    = sum_r;
    res_nxt    = '0;
    res_vld    = 1'b0;
    e_we = 1'b0;
    c_we = 1'b0;
    c_wa = vtx_r[VtxW-1:0];
    c_wd = '0;
    c_ra = vtx_r[VtxW-1:0];
    v_we = 1'b0;
    v_wd = {c_rd, sum_r};
    v_ra = in_dst;
    i_we = 1'b0;
    i_wa = c_rd[11:0];
    i_wd = {edg_r[11:0], e_rd[51:20], e_src};
    i_ra = in_pos;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_APPEND: begin
              res_vld = 1'b1;
              res_nxt.edge_total = stored_r;
              if (({1'b0, in_src} >= lim) || ({1'b0, in_dst} >= lim)) begin
                res_nxt.status = ST_RANGE;
              end else if (stored_r >= CntW'(MaxEdges)) begin
                res_nxt.status = ST_FULL;
              end else begin
                e_we = 1'b1;
                res_nxt.edge_number = stored_r[11:0];
                stored_nxt = stored_r + CntW'(1);
                res_nxt.edge_total = stored_nxt;
              end
            end
            OP_BUILD: begin
              vtx_nxt   = '0;
              state_nxt = S_CLR;
            end
            OP_QUERY: begin
              if (!built_r) begin
                res_vld = 1'b1;
                res_nxt.status = ST_NOT_BUILT;
              end else if ({1'b0, in_dst} >= lim) begin
                res_vld = 1'b1;
                res_nxt.status = ST_RANGE;
              end else begin
                state_nxt = S_QRY;
              end
            end
            OP_READ: begin
              if (!built_r) begin
                res_vld = 1'b1;
                res_nxt.status = ST_NOT_BUILT;
              end else if ({1'b0, in_pos} >= total_r) begin
                res_vld = 1'b1;
                res_nxt.status = ST_RANGE;
              end else begin
                state_nxt = S_RDE;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        c_we = 1'b1;
        vtx_nxt = vtx_r + LimW'(1);
        if (vtx_r == LimW'(MaxVertices - 1)) begin
          edg_nxt = '0;
          vtx_nxt = '0;
          sum_nxt = '0;
          state_nxt = (stored_r == '0) ? S_PRE_RD : S_CNT_RD;
        end
      end
      S_CNT_RD: state_nxt = S_CNT_CK;
      S_CNT_CK: begin
        c_ra = e_dst;
        if (e_ok) begin
          state_nxt = S_CNT_WR;
        end else begin
          edg_nxt = edg_r + CntW'(1);
          state_nxt = last_edge ? S_PRE_RD : S_CNT_RD;
        end
      end
      S_CNT_WR: begin
        c_we = 1'b1;
        c_wa = e_dst;
        c_wd = c_rd + CntW'(1);
        edg_nxt = edg_r + CntW'(1);
        state_nxt = last_edge ? S_PRE_RD : S_CNT_RD;
      end
      S_PRE_RD: state_nxt = S_PRE_WR;
      S_PRE_WR: begin
        v_we = 1'b1;
        c_we = 1'b1;
        c_wd = sum_r;
        sum_nxt = sum_r + c_rd;
        vtx_nxt = vtx_r + LimW'(1);
        state_nxt = S_PRE_RD;
        if (vtx_r == LimW'(MaxVertices - 1)) begin
          edg_nxt = '0;
          if (stored_r == '0) begin
            state_nxt = S_IDLE;
            total_nxt = sum_nxt;
            built_nxt = 1'b1;
            res_vld = 1'b1;
            res_nxt.edge_total = sum_nxt;
          end else begin
            state_nxt = S_SC_RD;
          end
        end
      end
      S_SC_RD: state_nxt = S_SC_CK;
      S_SC_CK: begin
        c_ra = e_dst;
        if (e_ok) begin
          state_nxt = S_SC_WR;
        end else begin
          edg_nxt = edg_r + CntW'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_SC_WR: begin
        c_we = 1'b1;
        c_wa = e_dst;
        c_wd = c_rd + CntW'(1);
        i_we = 1'b1;
        edg_nxt = edg_r + CntW'(1);
        state_nxt = S_SC_RD;
      end
      S_QRY: begin
        res_vld = 1'b1;
        res_nxt.start_position = v_rd[12:0];
        res_nxt.degree_count   = v_rd[25:13];
        state_nxt = S_IDLE;
      end
      S_RDE: begin
        res_vld = 1'b1;
        res_nxt.neighbor_vertex = i_rd[9:0];
        res_nxt.edge_type_out   = i_rd[41:10];
        res_nxt.edge_number     = i_rd[53:42];
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // end of scatter walk
    if (((state_r == S_SC_CK) && !e_ok) || (state_r == S_SC_WR)) begin
      if (last_edge) begin
        state_nxt = S_IDLE;
        total_nxt = sum_r;
        built_nxt = 1'b1;
        res_vld = 1'b1;
        res_nxt.edge_total = sum_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vlim_r      <= LimW'(MaxVertices);
      stored_r    <= '0;
      total_r     <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      stored_r <= stored_nxt;
      total_r  <= total_nxt;
      built_r  <= built_nxt;
      if (cfg_wr_en) begin
        vlim_r <= cfg_wr_data;
      end
      if (res_vld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    vtx_r <= vtx_nxt;
    edg_r <= edg_nxt;
    sum_r <= sum_nxt;
    if (res_vld) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

endmodule

### rtl/core/elr_ram.sv
module elr_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
